// ===== rtl/json_string_unescape_utf8_top_defines.svh =====
// Assertion macros for the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Package with types, codes and character constants of the JSON string unescaper.
package jsu_pkg;

    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_EOT      = 3'd4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;

    localparam logic [15:0] UTF8_LIM1 = 16'h0080;
    localparam logic [15:0] UTF8_LIM2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_count;
        logic [11:0] code_accum;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [2:0] err;
        logic       last;
    } result_t;

    typedef result_t [MAX_RES-1:0] res_grp_t;

    localparam result_t RES_NONE = '{data: 8'h00, kind: KIND_DATA, err: ERR_NONE, last: 1'b0};

endpackage

// ===== rtl/jsu_step.sv =====
// Decode state register and the per-byte step that yields up to three results.
module jsu_step
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_eot,
    output logic [CNT_W-1:0] res_cnt,
    output res_grp_t   res
);

    dec_state_t state_reg;
    dec_state_t state_next;

    logic [3:0]  hex_val;
    logic        hex_ok;
    logic [15:0] code;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_val = 4'(in_byte - 8'h30);
        end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
            hex_val = 4'(in_byte - 8'h57);
        end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
            hex_val = 4'(in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
        if (in_eot) begin
            hex_ok = 1'b0;
        end
    end

    assign code = {state_reg.code_accum, hex_val};

    always_comb begin
        state_next = state_reg;
        res_cnt    = CNT_W'(0);
        res        = {MAX_RES{RES_NONE}};
        unique case (state_reg.phase)
            PH_WAIT: begin
                if (in_eot) begin
                    res_cnt     = CNT_W'(1);
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_NO_QUOTE;
                    res[0].last = 1'b1;
                end else if (in_byte == CH_SPACE ||
                             (in_byte >= CH_TAB && in_byte <= CH_CR)) begin
                    // skip leading whitespace
                end else if (in_byte == CH_QUOTE) begin
                    state_next.phase = PH_STR;
                end else begin
                    res_cnt     = CNT_W'(1);
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_NO_QUOTE;
                    res[0].last = 1'b1;
                end
            end
            PH_STR: begin
                if (in_eot) begin
                    res_cnt     = CNT_W'(1);
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_EOT;
                    res[0].last = 1'b1;
                    state_next  = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
                end else if (in_byte == CH_QUOTE) begin
                    res_cnt     = CNT_W'(1);
                    res[0].kind = KIND_DONE;
                    res[0].last = 1'b1;
                    state_next  = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
                end else if (in_byte == CH_BSLASH) begin
                    state_next.phase = PH_ESC;
                end else begin
                    res_cnt     = CNT_W'(1);
                    res[0].data = in_byte;
                    res[0].last = 1'b1;
                end
            end
            PH_ESC: begin
                res_cnt          = CNT_W'(1);
                res[0].last      = 1'b1;
                state_next.phase = PH_STR;
                priority if (in_eot) begin
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_BAD_ESC;
                    state_next  = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
                end else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH ||
                             in_byte == CH_SLASH) begin
                    res[0].data = in_byte;
                end else if (in_byte == CH_B) begin
                    res[0].data = CH_BS;
                end else if (in_byte == CH_F) begin
                    res[0].data = CH_FF;
                end else if (in_byte == CH_N) begin
                    res[0].data = CH_LF;
                end else if (in_byte == CH_R) begin
                    res[0].data = CH_CR;
                end else if (in_byte == CH_T) begin
                    res[0].data = CH_TAB;
                end else if (in_byte == CH_U) begin
                    res_cnt     = CNT_W'(0);
                    res[0].last = 1'b0;
                    state_next  = '{phase: PH_HEX, hex_count: 2'd0, code_accum: 12'd0};
                end else begin
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_BAD_ESC;
                    state_next  = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
                end
            end
            PH_HEX: begin
                if (!hex_ok) begin
                    res_cnt     = CNT_W'(1);
                    res[0].kind = KIND_ERR;
                    res[0].err  = ERR_BAD_HEX;
                    res[0].last = 1'b1;
                    state_next  = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
                end else if (state_reg.hex_count != 2'd3) begin
                    state_next.code_accum = code[11:0];
                    state_next.hex_count  = state_reg.hex_count + 2'd1;
                end else begin
                    state_next = '{phase: PH_STR, hex_count: 2'd0, code_accum: 12'd0};
                    if (code < UTF8_LIM1) begin
                        res_cnt     = CNT_W'(1);
                        res[0].data = code[7:0];
                        res[0].last = 1'b1;
                    end else if (code < UTF8_LIM2) begin
                        res_cnt     = CNT_W'(2);
                        res[0].data = UTF8_LEAD2 | {3'd0, code[10:6]};
                        res[1].data = UTF8_CONT | {2'd0, code[5:0]};
                        res[1].last = 1'b1;
                    end else begin
                        res_cnt     = CNT_W'(3);
                        res[0].data = UTF8_LEAD3 | {4'd0, code[15:12]};
                        res[1].data = UTF8_CONT | {2'd0, code[11:6]};
                        res[2].data = UTF8_CONT | {2'd0, code[5:0]};
                        res[2].last = 1'b1;
                    end
                end
            end
            default: begin
                state_next = '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_WAIT, hex_count: 2'd0, code_accum: 12'd0};
        end else if (take) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/jsu_outbuf.sv =====
// Result register: holds one group of up to three results and sends one per cycle while m_ready is high.
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  logic [CNT_W-1:0] load_cnt,
    input  res_grp_t   load_res,
    input  logic       m_ready,
    output logic       m_valid,
    output result_t    m_res,
    output logic       free
);

    res_grp_t         ent_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             take;

    assign m_valid = (cnt_reg != CNT_W'(0));
    assign take    = m_valid && m_ready;
    assign free    = (cnt_reg == CNT_W'(0)) || (cnt_reg == CNT_W'(1) && m_ready);
    assign m_res   = ent_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_W'(0);
        end else if (load) begin
            cnt_reg <= load_cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // shift the group down one entry per beat
    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg <= load_res;
        end else if (take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
            ent_reg[MAX_RES-1] <= RES_NONE;
        end
    end

    `JSU_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> cnt_reg == CNT_W'(0), "buffer not empty after reset")
    `JSU_ASSERT(a_last_pos, cnt_reg != CNT_W'(0) |-> (ent_reg[0].last == (cnt_reg == CNT_W'(1))), "last flag not on final result")
    `JSU_ASSERT(a_hold_cnt, (cnt_reg != CNT_W'(0) && !take) |=> cnt_reg == $past(cnt_reg), "group changed while stalled")
    `JSU_ASSERT(a_err_code, (cnt_reg != CNT_W'(0) && ent_reg[0].kind != KIND_ERR) |-> ent_reg[0].err == ERR_NONE, "error code on non-error result")

endmodule

// ===== rtl/json_string_unescape_utf8_top.sv =====
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
// Input stream: one text byte per beat in s_tdata[7:0]; s_tuser high marks
// end of text (the byte is then ignored). Output stream: one result per beat,
// m_tuser = kind (data byte, string complete, error), m_tdata[7:0] = decoded
// byte, m_tdata[10:8] = error code, m_tlast on the final result of an input.
// Leading whitespace is skipped, escapes are expanded, a \uXXXX escape yields
// one to three UTF-8 bytes, the closing quote yields a completion result.
// Each input beat is registered in the input register and then in the result
// register before its first result can leave on m_tvalid.
// Throughput: one input beat per cycle while each byte gives at most one
// result and the receiver is ready; a byte that gives two or three results
// holds the input back while the one result register sends a beat per ready cycle.
// The input register keeps taking a beat while a result waits on a stalled
// receiver; s_tready drops once both the input register and the result
// register are occupied. Results are held stable until m_tready.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to waiting for an opening quote.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eot_reg;
    logic             buf_free;
    logic             in_take;
    logic [CNT_W-1:0] res_cnt;
    res_grp_t         res;
    result_t          head;

    assign in_take  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (in_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tuser;
        end
    end

    jsu_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (in_take),
        .in_byte (in_byte_reg),
        .in_eot  (in_eot_reg),
        .res_cnt (res_cnt),
        .res     (res)
    );

    jsu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_take),
        .load_cnt (res_cnt),
        .load_res (res),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_res    (head),
        .free     (buf_free)
    );

    assign m_tdata = {5'd0, head.err, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== tb/json_string_unescape_utf8_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the JSON string unescaper: directed table, random strings, stalls.
module json_string_unescape_utf8_top_tb;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 185;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTS   = 40;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_VT      = 8'h0b;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam result_t WANT_NO_QUOTE = '{data: 8'h00, kind: KIND_ERR, err: ERR_NO_QUOTE,
                                          last: 1'b1};
    localparam result_t WANT_BAD_ESC  = '{data: 8'h00, kind: KIND_ERR, err: ERR_BAD_ESC,
                                          last: 1'b1};
    localparam result_t WANT_EOT      = '{data: 8'h00, kind: KIND_ERR, err: ERR_EOT,
                                          last: 1'b1};
    localparam result_t WANT_DONE     = '{data: 8'h00, kind: KIND_DONE, err: ERR_NONE,
                                          last: 1'b1};
    localparam result_t WANT_ZERO     = '{data: 8'h00, kind: KIND_DATA, err: ERR_NONE,
                                          last: 1'b1};
    localparam result_t WANT_FF       = '{data: 8'hff, kind: KIND_DATA, err: ERR_NONE,
                                          last: 1'b1};

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         fixed;   // use the typed result instead of the decoder prediction
        result_t    want;
    } text_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tuser  = 1'b0;    // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [10:8] error_code, [15:11] zero
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;

    json_string_unescape_utf8_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Directed text: waiting-state errors, whitespace, raw extremes, escapes, error paths other than a bad hex digit.
    text_item_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, WANT_NO_QUOTE},   // end of text right after reset
        '{8'hff, 1'b0, 1'b1, WANT_NO_QUOTE},   // junk before the opening quote
        '{CH_SPACE,  1'b0, 1'b0, RES_NONE},
        '{CH_VT,     1'b0, 1'b0, RES_NONE},
        '{CH_QUOTE,  1'b0, 1'b0, RES_NONE},
        '{8'h00,     1'b0, 1'b1, WANT_ZERO},   // zero byte passes through
        '{8'hff,     1'b0, 1'b1, WANT_FF},
        '{CH_BSLASH, 1'b0, 1'b0, RES_NONE},
        '{CH_T,      1'b0, 1'b0, RES_NONE},
        '{CH_BSLASH, 1'b0, 1'b0, RES_NONE},
        '{CH_U,      1'b0, 1'b0, RES_NONE},
        '{CH_UPPER_F, 1'b0, 1'b0, RES_NONE},
        '{CH_F,      1'b0, 1'b0, RES_NONE},
        '{CH_F,      1'b0, 1'b0, RES_NONE},
        '{CH_UPPER_F, 1'b0, 1'b0, RES_NONE},   // \uFFFF: three-byte form
        '{CH_BSLASH, 1'b0, 1'b0, RES_NONE},
        '{8'h71,     1'b0, 1'b1, WANT_BAD_ESC},
        '{CH_QUOTE,  1'b0, 1'b0, RES_NONE},
        '{CH_BSLASH, 1'b0, 1'b0, RES_NONE},
        '{8'hff,     1'b1, 1'b1, WANT_BAD_ESC}, // text ends after a backslash
        '{CH_QUOTE,  1'b0, 1'b0, RES_NONE},
        '{8'h00,     1'b1, 1'b1, WANT_EOT},
        '{CH_QUOTE,  1'b0, 1'b0, RES_NONE},
        '{CH_QUOTE,  1'b0, 1'b1, WANT_DONE},
        '{8'h00,     1'b1, 1'b1, WANT_NO_QUOTE} // text ends after a completed string
    };

    text_item_t text_items [$];
    result_t    pending_results [$];

    phase_t      dec_phase   = PH_WAIT;
    logic [1:0]  dec_hex_cnt = 2'd0;
    logic [11:0] dec_code    = 12'd0;

    int errors        = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int rx_mode       = 0;
    int rx_left       = 0;
    result_t rx_want;

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                     results_seen, field, got, want);
    endtask

    // Bit 4 set when the character is a hex digit, low nibble holds its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return {1'b1, 4'(c - CH_DIGIT0)};
        if (c >= CH_LOWER_A && c <= CH_F) return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] escape_target(input logic [7:0] c, output bit ok);
        ok = 1'b1;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: return c;
            CH_B: return CH_BS;
            CH_F: return CH_FF;
            CH_N: return CH_LF;
            CH_R: return CH_CR;
            CH_T: return CH_TAB;
            default: begin
                ok = 1'b0;
                return 8'h00;
            end
        endcase
    endfunction

    function automatic result_t mk_result(input logic [7:0] d, input kind_t k,
                                          input logic [2:0] e);
        return '{data: d, kind: k, err: e, last: 1'b0};
    endfunction

    function automatic void clear_decoder();
        dec_phase   = PH_WAIT;
        dec_hex_cnt = 2'd0;
        dec_code    = 12'd0;
    endfunction

    // Advance the decoder state by one text byte and return the results it yields.
    function automatic void decode_byte(input logic [7:0] c, input logic eot,
                                        output result_t res [MAX_RES], output int n);
        logic [4:0]  hx;
        logic [15:0] code;
        logic [7:0]  b;
        bit          ok;
        n = 0;
        case (dec_phase)
            PH_WAIT: begin
                if (eot) begin
                    res[n] = mk_result(8'h00, KIND_ERR, ERR_NO_QUOTE); n++;
                end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    // skip leading whitespace
                end else if (c == CH_QUOTE) begin
                    dec_phase = PH_STR;
                end else begin
                    res[n] = mk_result(8'h00, KIND_ERR, ERR_NO_QUOTE); n++;
                end
            end
            PH_STR: begin
                if (eot) begin
                    res[n] = mk_result(8'h00, KIND_ERR, ERR_EOT); n++;
                    clear_decoder();
                end else if (c == CH_QUOTE) begin
                    res[n] = mk_result(8'h00, KIND_DONE, ERR_NONE); n++;
                    clear_decoder();
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    res[n] = mk_result(c, KIND_DATA, ERR_NONE); n++;
                end
            end
            PH_ESC: begin
                b = escape_target(c, ok);
                if (!eot && c == CH_U) begin
                    dec_phase   = PH_HEX;
                    dec_hex_cnt = 2'd0;
                    dec_code    = 12'd0;
                end else if (!eot && ok) begin
                    res[n] = mk_result(b, KIND_DATA, ERR_NONE); n++;
                    dec_phase = PH_STR;
                end else begin
                    res[n] = mk_result(8'h00, KIND_ERR, ERR_BAD_ESC); n++;
                    clear_decoder();
                end
            end
            default: begin
                hx = hex_nibble(c);
                if (eot || !hx[4]) begin
                    res[n] = mk_result(8'h00, KIND_ERR, ERR_BAD_HEX); n++;
                    clear_decoder();
                end else if (dec_hex_cnt < 2'd3) begin
                    dec_code    = {dec_code[7:0], hx[3:0]};
                    dec_hex_cnt = dec_hex_cnt + 2'd1;
                end else begin
                    code = {dec_code, hx[3:0]};
                    if (code < UTF8_LIM1) begin
                        res[n] = mk_result(code[7:0], KIND_DATA, ERR_NONE); n++;
                    end else if (code < UTF8_LIM2) begin
                        res[n] = mk_result(UTF8_LEAD2 | {3'b000, code[10:6]}, KIND_DATA,
                                           ERR_NONE); n++;
                        res[n] = mk_result(UTF8_CONT | {2'b00, code[5:0]}, KIND_DATA,
                                           ERR_NONE); n++;
                    end else begin
                        res[n] = mk_result(UTF8_LEAD3 | {4'h0, code[15:12]}, KIND_DATA,
                                           ERR_NONE); n++;
                        res[n] = mk_result(UTF8_CONT | {2'b00, code[11:6]}, KIND_DATA,
                                           ERR_NONE); n++;
                        res[n] = mk_result(UTF8_CONT | {2'b00, code[5:0]}, KIND_DATA,
                                           ERR_NONE); n++;
                    end
                    clear_decoder();
                    dec_phase = PH_STR;
                end
            end
        endcase
        if (n > 0) res[n-1].last = 1'b1;
    endfunction

    function automatic void push_text(input logic [7:0] c, input logic eot);
        text_items.push_back('{c, eot, 1'b0, RES_NONE});
    endfunction

    function automatic void push_hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            push_text(CH_DIGIT0 + 8'(nib), 1'b0);
        else if ($urandom_range(0, 1) != 0)
            push_text(CH_UPPER_A + 8'(nib) - 8'd10, 1'b0);
        else
            push_text(CH_LOWER_A + 8'(nib) - 8'd10, 1'b0);
    endfunction

    // One quoted string, sometimes after junk, with random content, mostly well formed, sometimes broken at the end.
    function automatic void gen_string();
        int          k;
        int          sel;
        logic [7:0]  c;
        logic [15:0] code;
        logic [4:0]  hx;
        bit          ok;
        k = $urandom_range(0, 2);
        repeat (k) begin
            case ($urandom_range(0, 5))
                0: push_text(CH_SPACE, 1'b0);
                1: push_text(CH_TAB, 1'b0);
                2: push_text(CH_LF, 1'b0);
                3: push_text(CH_VT, 1'b0);
                4: push_text(CH_FF, 1'b0);
                default: push_text(CH_CR, 1'b0);
            endcase
        end
        if ($urandom_range(0, 9) == 0) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
            push_text(c, 1'b0);
        end
        push_text(CH_QUOTE, 1'b0);
        k = $urandom_range(1, 6);
        repeat (k) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE || c == CH_BSLASH);
                push_text(c, 1'b0);
            end else if (sel < 65) begin
                push_text(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0: push_text(CH_QUOTE, 1'b0);
                    1: push_text(CH_BSLASH, 1'b0);
                    2: push_text(CH_SLASH, 1'b0);
                    3: push_text(CH_B, 1'b0);
                    4: push_text(CH_F, 1'b0);
                    5: push_text(CH_N, 1'b0);
                    6: push_text(CH_R, 1'b0);
                    default: push_text(CH_T, 1'b0);
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0: code = 16'($urandom_range(0, 16'h007f));
                    1: code = 16'($urandom_range(16'h0080, 16'h07ff));
                    2: code = 16'($urandom_range(16'h0800, 16'hffff));
                    default: code = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
                endcase
                push_text(CH_BSLASH, 1'b0);
                push_text(CH_U, 1'b0);
                push_hex_digit(code[15:12]);
                push_hex_digit(code[11:8]);
                push_hex_digit(code[7:4]);
                push_hex_digit(code[3:0]);
            end
        end
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            push_text(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 9) == 0) push_text(8'($urandom_range(0, 255)), 1'b1);
        end else if (sel < 84) begin
            push_text(8'($urandom_range(0, 255)), 1'b1);
        end else if (sel < 88) begin
            push_text(CH_BSLASH, 1'b0);
            push_text(8'($urandom_range(0, 255)), 1'b1);
        end else if (sel < 92) begin
            push_text(CH_BSLASH, 1'b0);
            do begin
                c = 8'($urandom_range(0, 255));
                void'(escape_target(c, ok));
            end while (ok || c == CH_U);
            push_text(c, 1'b0);
        end else begin
            push_text(CH_BSLASH, 1'b0);
            push_text(CH_U, 1'b0);
            k = $urandom_range(0, 3);
            repeat (k) push_hex_digit(4'($urandom_range(0, 15)));
            if (sel < 96) begin
                do begin
                    c  = 8'($urandom_range(0, 255));
                    hx = hex_nibble(c);
                end while (hx[4]);
                push_text(c, 1'b0);
            end else begin
                push_text(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endfunction

    // Sender: bursts of beats with random gaps; predict on every accepted beat.
    initial begin
        text_item_t item;
        result_t    step_res [MAX_RES];
        int         n;
        int         burst;
        foreach (directed_rows[i]) text_items.push_back(directed_rows[i]);
        while (text_items.size() < $size(directed_rows) + RANDOM_ITEMS) gen_string();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst = $urandom_range(1, 8);
        for (int i = 0; i < text_items.size(); i++) begin
            item = text_items[i];
            s_tvalid <= 1'b1;
            s_tdata  <= item.ch;
            s_tuser  <= item.eot;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            decode_byte(item.ch, item.eot, step_res, n);
            if (item.fixed)
                pending_results.push_back(item.want);
            else
                for (int k = 0; k < n; k++) pending_results.push_back(step_res[k]);
            if (burst == 0) begin
                // long bursts now and then keep the input saturated
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                burst--;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: switch between always ready, mostly ready and mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 40);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 0);
            end else begin
                rx_want = pending_results.pop_front();
                if (m_tdata[7:0] != rx_want.data)
                    report_mismatch("out_byte", m_tdata[7:0], rx_want.data);
                if (m_tuser != rx_want.kind)
                    report_mismatch("kind", m_tuser, rx_want.kind);
                if (m_tdata[10:8] != rx_want.err)
                    report_mismatch("error_code", m_tdata[10:8], rx_want.err);
                if (m_tlast != rx_want.last)
                    report_mismatch("last", m_tlast, rx_want.last);
                if (m_tdata[15:11] != 5'd0)
                    report_mismatch("tdata pad", m_tdata[15:11], 0);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
